// ===== hdl/wbmp_pkg.sv =====
// Shared constants and types for the windowed byte mean pool.
package wbmp_pkg;

	// Width of the byte position counter.
	localparam int unsigned CNT_W = 16;
	// Width of one input byte and of one result byte.
	localparam int unsigned BYTE_W = 8;
	// Width of the running sum, which wraps at this width.
	localparam int unsigned SUM_W = CNT_W + BYTE_W;
	// Width of the window length register.
	localparam int unsigned LEN_W = 16;
	// Compare width that holds both the incremented position and the length.
	localparam int unsigned CMP_W = (CNT_W + 1 > LEN_W + 1) ? CNT_W + 1 : LEN_W + 1;
	// Width of the divider step counter.
	localparam int unsigned ITER_W = $clog2(SUM_W + 1);

	// Largest window length that the position counter can reach.
	localparam logic [LEN_W-1:0] LEN_CAP =
		(CNT_W >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << CNT_W) - 64'd1);
	// Window length after reset.
	localparam logic [LEN_W-1:0] WIN_RESET = LEN_W'(16384);

	// Divider sequencer states.
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
		logic             ack;
	} div_req_t;

	// Status and result of the shared divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/windowed_byte_mean_pool.sv =====
// Top level of the windowed byte mean pool.
// Bytes are summed into back-to-back windows of window_length bytes (zero acts as
// one), and each full window yields one item: the sum divided by the length,
// truncated, with its low eight bits read as a signed byte. A byte that does not
// close a window is taken while the divider is idle, so a stream runs at one byte
// per cycle. A byte that closes a window starts the shared divider, which yields
// one quotient bit per step over 24 steps (CNT_W + BYTE_W); in_ready stays low
// until its quotient is handed to the output register, and longer while that
// register is still full. Bytes that do not close a window are accepted while a
// result waits at the output. Write cfg_data only while the block is idle.
module windowed_byte_mean_pool (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wbmp_pkg::LEN_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wbmp_pkg::BYTE_W-1:0]        sample_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [wbmp_pkg::BYTE_W-1:0] window_mean
);

	wbmp_pkg::div_req_t           div_req;
	wbmp_pkg::div_rsp_t           div_rsp;
	logic                         take;
	logic                         complete;
	logic [wbmp_pkg::SUM_W-1:0]   sum_next;
	logic [wbmp_pkg::LEN_W-1:0]   len_eff;
	logic                         out_valid_q;
	logic [wbmp_pkg::BYTE_W-1:0]  mean_q;
	logic                         out_free;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign in_ready = !div_rsp.busy;
	assign take = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	wbmp_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.take        (take),
		.sample_byte (sample_byte),
		.complete    (complete),
		.sum_next    (sum_next),
		.len_eff     (len_eff)
	);

	// A byte that closes its window starts the divider.
	always_comb begin
		div_req.start = take && complete;
		div_req.dividend = sum_next;
		div_req.divisor = len_eff;
		div_req.ack = div_rsp.done && out_free;
	end

	wbmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register holds a finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_req.ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.ack) begin
			mean_q <= div_rsp.quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign window_mean = $signed(mean_q);

endmodule

// ===== hdl/wbmp_accum.sv =====
// Window length register, running sum and position counter.
module wbmp_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wbmp_pkg::LEN_W-1:0]   cfg_data,
	input  logic                         take,
	input  logic [wbmp_pkg::BYTE_W-1:0]  sample_byte,
	output logic                         complete,
	output logic [wbmp_pkg::SUM_W-1:0]   sum_next,
	output logic [wbmp_pkg::LEN_W-1:0]   len_eff
);

	logic [wbmp_pkg::LEN_W-1:0] len_q;
	logic [wbmp_pkg::SUM_W-1:0] sum_q;
	logic [wbmp_pkg::CNT_W-1:0] pos_q;
	logic [wbmp_pkg::LEN_W-1:0] len_nz;
	logic [wbmp_pkg::CMP_W-1:0] count;

	// A zero length acts as one; a length past the counter range saturates.
	always_comb begin
		len_nz = (len_q == '0) ? wbmp_pkg::LEN_W'(1) : len_q;
		len_eff = (len_nz > wbmp_pkg::LEN_CAP) ? wbmp_pkg::LEN_CAP : len_nz;
	end

	// Sum including this byte, and the position it would reach.
	assign sum_next = sum_q + wbmp_pkg::SUM_W'(sample_byte);
	assign count = wbmp_pkg::CMP_W'(pos_q) + wbmp_pkg::CMP_W'(1);
	assign complete = count >= wbmp_pkg::CMP_W'(len_eff);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= wbmp_pkg::WIN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// Accumulate each accepted byte; clear when its window closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			if (complete) begin
				sum_q <= '0;
				pos_q <= '0;
			end else begin
				sum_q <= sum_next;
				pos_q <= count[wbmp_pkg::CNT_W-1:0];
			end
		end
	end

endmodule

// ===== hdl/wbmp_div.sv =====
// Restoring divider that yields one quotient bit per cycle under a small sequencer.
module wbmp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wbmp_pkg::div_req_t req,
	output wbmp_pkg::div_rsp_t rsp
);

	wbmp_pkg::div_state_t state_q, state_d;
	logic [wbmp_pkg::LEN_W-1:0]  rem_q;
	logic [wbmp_pkg::SUM_W-1:0]  quo_q;
	logic [wbmp_pkg::LEN_W-1:0]  dvs_q;
	logic [wbmp_pkg::ITER_W-1:0] iter_q;
	logic [wbmp_pkg::LEN_W:0]    shifted;
	logic [wbmp_pkg::LEN_W:0]    trial;
	logic                        fits;

	// One step: bring down the next dividend bit and try to subtract.
	always_comb begin
		shifted = {rem_q, quo_q[wbmp_pkg::SUM_W-1]};
		trial = shifted - {1'b0, dvs_q};
		fits = shifted >= {1'b0, dvs_q};
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wbmp_pkg::DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and status; only the low byte of the quotient is delivered.
	always_comb begin
		state_d = state_q;
		rsp.busy = 1'b1;
		rsp.done = 1'b0;
		rsp.quotient = quo_q[wbmp_pkg::BYTE_W-1:0];
		case (state_q)
			wbmp_pkg::DIV_IDLE: begin
				rsp.busy = 1'b0;
				if (req.start) begin
					state_d = wbmp_pkg::DIV_RUN;
				end
			end
			wbmp_pkg::DIV_RUN: begin
				if (iter_q == wbmp_pkg::ITER_W'(1)) begin
					state_d = wbmp_pkg::DIV_DONE;
				end
			end
			wbmp_pkg::DIV_DONE: begin
				rsp.done = 1'b1;
				if (req.ack) begin
					state_d = wbmp_pkg::DIV_IDLE;
				end
			end
			default: begin
				state_d = wbmp_pkg::DIV_IDLE;
			end
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (state_q == wbmp_pkg::DIV_IDLE && req.start) begin
			iter_q <= wbmp_pkg::ITER_W'(wbmp_pkg::SUM_W);
		end else if (state_q == wbmp_pkg::DIV_RUN) begin
			iter_q <= iter_q - wbmp_pkg::ITER_W'(1);
		end
	end

	// Datapath: load operands, then shift quotient bits in from the right.
	always_ff @(posedge clk) begin
		if (state_q == wbmp_pkg::DIV_IDLE && req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (state_q == wbmp_pkg::DIV_RUN) begin
			rem_q <= fits ? trial[wbmp_pkg::LEN_W-1:0] : shifted[wbmp_pkg::LEN_W-1:0];
			quo_q <= {quo_q[wbmp_pkg::SUM_W-2:0], fits};
		end
	end

endmodule

// ===== hdl/wbmp_chk.sv =====
// Port-level checker for the windowed byte mean pool, bound to the top level.
module wbmp_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [wbmp_pkg::BYTE_W-1:0] window_mean
);

	// A stalled item stays put with its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_mean))
		else $error("output item changed while stalled");

	// The input side only stalls after it has taken a byte.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input stalled without an accepted item");

	// A division keeps in_ready low also in the cycle after it falls.
	a_stall_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |=> !in_ready)
		else $error("divide finished too early");

	// A new result only appears as a division ends.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a division");

endmodule

bind windowed_byte_mean_pool wbmp_chk u_wbmp_chk (.*);

// ===== verif/wbmp_checker.sv =====
`timescale 1ns / 100ps
// Checker for the windowed byte mean pool: predicts each window mean and compares it.
module wbmp_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [wbmp_pkg::LEN_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [wbmp_pkg::BYTE_W-1:0]        sample_byte,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [wbmp_pkg::BYTE_W-1:0] window_mean,
	output int                                 mismatches,
	output int                                 outstanding
);

	// Shadow copy of the length register and of the window accumulator.
	logic [wbmp_pkg::LEN_W-1:0] shadow_length;
	logic [wbmp_pkg::SUM_W-1:0] window_sum;
	logic [wbmp_pkg::CNT_W-1:0] window_count;
	// Means still owed by the block, oldest first.
	logic signed [wbmp_pkg::BYTE_W-1:0] pending_means[$];

	// A length of zero acts as one, and the counter caps the usable length.
	function automatic logic [wbmp_pkg::LEN_W-1:0] usable_length(
		input logic [wbmp_pkg::LEN_W-1:0] len);
		if (len == '0) begin
			return wbmp_pkg::LEN_W'(1);
		end
		if (len > wbmp_pkg::LEN_CAP) begin
			return wbmp_pkg::LEN_CAP;
		end
		return len;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [wbmp_pkg::LEN_W-1:0]         len;
		logic [wbmp_pkg::CMP_W-1:0]         next_count;
		logic [wbmp_pkg::SUM_W-1:0]         quotient;
		logic signed [wbmp_pkg::BYTE_W-1:0] mean_exp;

		if (!arst_n) begin
			shadow_length = wbmp_pkg::WIN_RESET;
			window_sum    = '0;
			window_count  = '0;
			pending_means.delete();
		end else begin
			// Compare an accepted result with the oldest expected mean.
			if (out_valid && out_ready) begin
				if (pending_means.size() == 0) begin
					$error("window_mean: unexpected item, got %0d", window_mean);
					mismatches++;
				end else begin
					mean_exp = pending_means.pop_front();
					if (window_mean !== mean_exp) begin
						$error("window_mean mismatch: expected %0d, got %0d",
							mean_exp, window_mean);
						mismatches++;
					end
				end
			end

			// Accumulate an accepted byte; a full window owes one mean.
			if (in_valid && in_ready) begin
				len        = usable_length(shadow_length);
				window_sum = window_sum + wbmp_pkg::SUM_W'(sample_byte);
				next_count = wbmp_pkg::CMP_W'(window_count) + wbmp_pkg::CMP_W'(1);
				if (next_count < wbmp_pkg::CMP_W'(len)) begin
					window_count = next_count[wbmp_pkg::CNT_W-1:0];
				end else begin
					quotient = window_sum / wbmp_pkg::SUM_W'(len);
					pending_means.push_back(quotient[wbmp_pkg::BYTE_W-1:0]);
					window_sum   = '0;
					window_count = '0;
				end
			end

			// Register write; it takes effect from the next byte on.
			if (cfg_valid && cfg_ready) begin
				shadow_length = cfg_data;
			end
		end
		outstanding = pending_means.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives bytes, window lengths and result backpressure, and gives the verdict.
module tb;

	localparam int unsigned CLK_PERIOD   = 20;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	// Cycles to let a divide finish before a register write or the verdict.
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned ITEMS_PER_PHASE = 160;

	// Byte mixes for one stretch of the stream.
	typedef enum int unsigned {
		MIX_UNIFORM,
		MIX_HIGH,
		MIX_LOW,
		MIX_EXTREME
	} byte_mix_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [wbmp_pkg::LEN_W-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [wbmp_pkg::BYTE_W-1:0]         sample_byte = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [wbmp_pkg::BYTE_W-1:0]  window_mean;
	int                                  mismatches;
	int                                  outstanding;

	// Percent of cycles where the sender idles and the receiver stalls.
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_by_phase[4]  = '{0, 78, 0, 34};
	int unsigned stall_by_phase[4] = '{0, 0, 78, 34};

	windowed_byte_mean_pool i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_byte (sample_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_mean (window_mean)
	);

	wbmp_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_byte (sample_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_mean (window_mean),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Receiver backpressure.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tb NOT OK");
		$finish;
	end

	function automatic logic [wbmp_pkg::BYTE_W-1:0] pick_byte(input byte_mix_t mix);
		case (mix)
			MIX_HIGH:    return wbmp_pkg::BYTE_W'($urandom_range(255, 192));
			MIX_LOW:     return wbmp_pkg::BYTE_W'($urandom_range(63, 0));
			MIX_EXTREME: return $urandom_range(1) ? {wbmp_pkg::BYTE_W{1'b1}} : '0;
			default:     return wbmp_pkg::BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// Offer one byte after a random gap and hold it until it is taken.
	task automatic push_byte(input logic [wbmp_pkg::BYTE_W-1:0] value);
		int unsigned gap;

		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_byte <= value;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Stop the stream, let every owed mean drain, then write the window length.
	task automatic set_window_length(input int unsigned len);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= wbmp_pkg::LEN_W'(len);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned len;
		int unsigned count;
		int unsigned items_left;
		int unsigned pick;
		byte_mix_t   mix;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A partial window at the reset length, closed by a shorter length.
		repeat (10) push_byte(pick_byte(MIX_UNIFORM));
		set_window_length(3);
		push_byte(pick_byte(MIX_UNIFORM));
		// A partial window at the longest length, closed by the first byte at length one.
		set_window_length(65535);
		repeat (4) push_byte({wbmp_pkg::BYTE_W{1'b1}});

		// Single-byte windows across the byte range, including both sign halves.
		set_window_length(1);
		push_byte(8'd0);
		push_byte(8'd255);
		push_byte(8'd128);
		push_byte(8'd127);
		push_byte(8'd1);
		// A zero length behaves as one.
		set_window_length(0);
		push_byte(8'd200);
		push_byte(8'd3);
		// Truncation and the top of the mean range.
		set_window_length(2);
		push_byte(8'd255);
		push_byte(8'd255);
		push_byte(8'd0);
		push_byte(8'd1);
		set_window_length(3);
		push_byte(8'd1);
		push_byte(8'd1);
		push_byte(8'd0);
		// Shrinking the length mid-window closes it on the next byte with a wide quotient.
		set_window_length(8);
		repeat (5) push_byte(8'd255);
		set_window_length(2);
		push_byte(8'd255);
		// A huge length left partial, then cut short by a small one.
		set_window_length(40000);
		repeat (3) push_byte(8'd250);
		set_window_length(4);
		push_byte(8'd7);

		// Random stretches of lengths and bytes under each mix of idling and stalling.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct   = idle_by_phase[phase];
			stall_pct  = stall_by_phase[phase];
			items_left = ITEMS_PER_PHASE;
			while (items_left > 0) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					len = 0;
				end else if (pick < 70) begin
					len = $urandom_range(8, 1);
				end else if (pick < 90) begin
					len = $urandom_range(40, 9);
				end else if (pick < 96) begin
					len = $urandom_range(300, 41);
				end else begin
					len = $urandom_range(65535, 301);
				end
				set_window_length(len);
				if (len > 300) begin
					count = $urandom_range(20, 1);
				end else begin
					count = $urandom_range(60, 1);
				end
				if (count > items_left) begin
					count = items_left;
				end
				mix = byte_mix_t'($urandom_range(3));
				repeat (count) push_byte(pick_byte(mix));
				items_left -= count;
			end
		end

		// Drain and give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
